FILE: rtl/core/fnvkh_pkg.sv
`timescale 1ns / 1ps

package fnvkh_pkg;

   // lane primes and seeds
   localparam logic [63:0] LOW_PRIME   = 64'd1099511628211;
   localparam logic [63:0] HIGH_PRIME  = 64'd14029467366897019727;
   localparam logic [63:0] LOW_SEED    = 64'd1469598103934665603;
   localparam logic [63:0] HIGH_SEED   = LOW_PRIME ^ 64'h9e3779b97f4a7c15;
   localparam logic [7:0]  BYTE_OFFSET = 8'h9d;

   // operation codes
   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_BYTE    = 2'd1;
   localparam logic [1:0] OP_LENGTH  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] data_value;
      logic        emit;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_low;
      logic [63:0] hash_high;
   } rsp_type;

endpackage

FILE: rtl/core/fnvkh_mul32.sv
`timescale 1ns / 1ps

module fnvkh_mul32 (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);
   logic [63:0] prod_in;

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/core/fnvkh_core.sv
`timescale 1ns / 1ps

module fnvkh_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fnvkh_pkg::req_type req,
   output logic              idle,
   input  logic              out_free,
   output logic              push,
   output fnvkh_pkg::rsp_type result
);
   import fnvkh_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [63:0] data_ff, data_in;
   logic        emit_ff, emit_in;
   logic [63:0] low_ff, low_in;
   logic [63:0] high_ff, high_in;
   logic [63:0] acc_ff, acc_in;

   logic        lane_sel;
   logic [1:0]  sub;
   logic [7:0]  byte_val;
   logic [7:0]  byte_mixed;
   logic [63:0] operand;
   logic [63:0] prime;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;
   logic [63:0] prod_hi;
   logic [63:0] lane_sum;

   // phase: bit 2 picks the lane, bits 1:0 walk the three partial products
   assign lane_sel   = phase_ff[2];
   assign sub        = phase_ff[1:0];
   assign byte_val   = data_ff[7:0];
   assign byte_mixed = byte_val + BYTE_OFFSET;
   assign operand    = lane_sel ? (high_ff ^ {56'd0, byte_mixed})
                                : (low_ff ^ {56'd0, byte_val});
   assign prime      = lane_sel ? HIGH_PRIME : LOW_PRIME;

   // lo*lo, lo*hi, hi*lo; the hi*hi term falls off the top
   assign mul_a = (sub == 2'd2) ? operand[63:32] : operand[31:0];
   assign mul_b = (sub == 2'd1) ? prime[63:32] : prime[31:0];

   fnvkh_mul32 u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod)
   );

   assign prod_hi  = {prod[31:0], 32'd0};
   assign lane_sum = acc_ff + prod_hi;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      data_in       = data_ff;
      emit_in       = emit_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      acc_in        = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               emit_in  = req.emit;
               data_in  = req.data_value;
               phase_in = 3'd0;
               unique case (req.operation)
                  OP_RESTART: begin
                     low_in   = LOW_SEED;
                     high_in  = HIGH_SEED;
                     state_in = ST_DONE;
                  end
                  OP_BYTE: begin
                     bytes_left_in = 3'd0;
                     state_in      = ST_MIX;
                  end
                  OP_LENGTH: begin
                     bytes_left_in = 3'd7;
                     state_in      = ST_MIX;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MIX: begin
            phase_in = phase_ff + 3'd1;
            case (sub)
               2'd1: acc_in = prod;
               2'd2: acc_in = lane_sum;
               2'd3: begin
                  if (lane_sel) begin
                     high_in       = lane_sum;
                     data_in       = {8'd0, data_ff[63:8]};
                     bytes_left_in = bytes_left_ff - 3'd1;
                     if (bytes_left_ff == 3'd0) begin
                        state_in = ST_DONE;
                     end
                  end else begin
                     low_in = lane_sum;
                  end
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!emit_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 3'd0;
         bytes_left_ff <= 3'd0;
         emit_ff       <= 1'b0;
         low_ff        <= LOW_SEED;
         high_ff       <= HIGH_SEED;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         emit_ff       <= emit_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
      end
      data_ff <= data_in;
      acc_ff  <= acc_in;
   end

   assign idle             = (state_ff == ST_IDLE);
   assign push             = (state_ff == ST_DONE) && emit_ff;
   assign result.hash_low  = low_ff;
   assign result.hash_high = high_ff;

   a_phase_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_MIX) |-> (phase_ff == 3'd0))
      else $error("phase counter not at zero outside mixing");

   a_restart_seeds: assert property (@(posedge clock) disable iff (reset)
      (start && idle && req.operation == OP_RESTART)
      |=> (low_ff == LOW_SEED && high_ff == HIGH_SEED))
      else $error("restart did not reload seeds");

   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && phase_ff == 3'd7 && bytes_left_ff == 3'd0)
      |=> (state_ff == ST_DONE))
      else $error("mixing did not end after last byte");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && phase_ff != 3'd7) |=> $stable(data_ff))
      else $error("byte shifter moved in mid byte");

endmodule

FILE: rtl/core/dual_lane_fnv_key_hash_top.sv
`timescale 1ns / 1ps

// 128-bit key hash of two 64-bit lanes (FNV-1a step and prime, own seed,
// low; offset-byte variant with a second prime high).
// req channel: valid/ready; operation selects restart from seeds, absorb the
// byte in data_value[7:0], or absorb all 64 bits of data_value as eight
// bytes, least significant first. emit asks for one item on rsp after the
// request is absorbed; without emit nothing comes out.
// rsp channel: valid/ready, hash_low and hash_high after the request.
// One 32x32 multiplier is reused for both lanes, three partial products per
// lane per byte, the low lane first and then the high lane.
// req_ready is high only while the sequencer is idle.
// A registered output stage holds the result; if the receiver stalls with a
// result still held and a new one is ready, the sequencer waits and takes no
// new request until the slot frees.
// Reset (synchronous, active high) loads both lanes with their seeds and
// drops rsp_valid.

module dual_lane_fnv_key_hash_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fnvkh_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fnvkh_pkg::rsp_type rsp_data
);
   import fnvkh_pkg::*;

   logic    core_idle;
   logic    core_push;
   rsp_type core_result;
   logic    out_free;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = core_idle;

   fnvkh_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (req_valid && req_ready),
      .req     (req_data),
      .idle    (core_idle),
      .out_free(out_free),
      .push    (core_push),
      .result  (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_push && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/tb_dual_lane_fnv_key_hash_top.sv
`timescale 1ns / 1ps

module tb_dual_lane_fnv_key_hash_top;
   import fnvkh_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 450;

   // expected hash results, built from a private copy of both lanes
   class hash_lane_scoreboard;
      logic [63:0] low_lane;
      logic [63:0] high_lane;
      rsp_type     hash_q[$];
      int          errors;

      function new();
         low_lane = LOW_SEED;
         high_lane = HIGH_SEED;
         errors = 0;
      endfunction

      function void absorb_byte(logic [7:0] b);
         logic [7:0] shifted;
         shifted = b + BYTE_OFFSET;
         low_lane = (low_lane ^ {56'd0, b}) * LOW_PRIME;
         high_lane = (high_lane ^ {56'd0, shifted}) * HIGH_PRIME;
      endfunction

      function void note_item(req_type item);
         rsp_type hash;
         case (item.operation)
            OP_RESTART: begin
               low_lane = LOW_SEED;
               high_lane = HIGH_SEED;
            end
            OP_BYTE: absorb_byte(item.data_value[7:0]);
            OP_LENGTH: begin
               for (int pos = 0; pos < 64; pos += 8)
                  absorb_byte(item.data_value[pos +: 8]);
            end
            default: ;
         endcase
         if (item.emit) begin
            hash.hash_low = low_lane;
            hash.hash_high = high_lane;
            hash_q.push_back(hash);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (hash_q.size() == 0) begin
            $display("%0t: unexpected hash item low=%h high=%h", $time, got.hash_low,
                     got.hash_high);
            errors++;
            return;
         end
         want = hash_q.pop_front();
         if (got.hash_low !== want.hash_low) begin
            $display("%0t: hash_low expected %h actual %h", $time, want.hash_low,
                     got.hash_low);
            errors++;
         end
         if (got.hash_high !== want.hash_high) begin
            $display("%0t: hash_high expected %h actual %h", $time, want.hash_high,
                     got.hash_high);
            errors++;
         end
      endfunction

      function int pending();
         return hash_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   hash_lane_scoreboard hash_book = new();

   int send_idle_pct = 35;
   int recv_idle_pct = 76;
   int items_sent = 0;
   int stall_count = 0;
   bit hold_toggle = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   dual_lane_fnv_key_hash_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // receiver: check accepted results, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         hash_book.check_result(rsp_data);
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count + 1 >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [63:0] value,
                            input logic emit_flag);
      req_type item;
      item.operation = op;
      item.data_value = value;
      item.emit = emit_flag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      hash_book.note_item(item);
      if (op != OP_UNUSED || emit_flag)
         items_sent++;
   endtask

   // one key as the host frames it: optional restart, length, then its bytes
   task automatic send_key();
      int n;
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(2) == 0)
         send_item(OP_RESTART, rand64(), $urandom_range(7) == 0);
      send_item(OP_LENGTH, ($urandom_range(4) == 0) ? rand64() : 64'(n),
                n == 0 || $urandom_range(5) == 0);
      for (int i = 0; i < n; i++)
         send_item(OP_BYTE, rand64(), i == n - 1 || $urandom_range(9) == 0);
   endtask

   task automatic send_noise();
      send_item(2'($urandom_range(3)), rand64(), 1'($urandom_range(1)));
   endtask

   task automatic run_random(input int target);
      while (items_sent < target) begin
         if ($urandom_range(4) == 0)
            send_noise();
         else
            send_key();
      end
   endtask

   initial begin
      int base;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seeds, unused code, byte extremes and offset wrap, length extremes
      send_item(OP_RESTART, '0, 1'b1);
      send_item(OP_UNUSED, '1, 1'b1);
      send_item(OP_UNUSED, '0, 1'b0);
      send_item(OP_BYTE, 64'h00, 1'b1);
      send_item(OP_BYTE, 64'hff, 1'b1);
      send_item(OP_BYTE, 64'h63, 1'b1);
      send_item(OP_BYTE, '1, 1'b1);
      send_item(OP_BYTE, 64'hffff_ffff_ffff_ff00, 1'b0);
      send_item(OP_LENGTH, '0, 1'b1);
      send_item(OP_LENGTH, '1, 1'b1);
      send_item(OP_LENGTH, 64'h8000_0000_0000_0001, 1'b0);
      send_item(OP_UNUSED, 64'h5a5a, 1'b1);
      send_item(OP_RESTART, '1, 1'b0);
      send_item(OP_LENGTH, 64'd3, 1'b0);
      send_item(OP_BYTE, 64'h61, 1'b0);
      send_item(OP_BYTE, 64'h62, 1'b0);
      send_item(OP_BYTE, 64'h63, 1'b1);
      send_item(OP_RESTART, '0, 1'b1);

      base = items_sent;
      run_random(base + RANDOM_ITEMS / 3);

      send_idle_pct = 76;
      recv_idle_pct = 35;
      run_random(base + 2 * RANDOM_ITEMS / 3);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // receiver stops for a long stretch while items keep coming
      hold_toggle = ~hold_toggle;
      for (int i = 0; i < 8; i++)
         send_item(OP_BYTE, rand64(), 1'b1);
      run_random(base + RANDOM_ITEMS);

      @(posedge clock);
      req_valid <= 1'b0;
      while (hash_book.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (hash_book.errors == 0 && hash_book.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
